>>> hw/rtl/tapd_pkg.sv
// tapd_pkg: shared types, widths, constants and register indexes
// for the tray angle pd controller; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tapd_pkg;

    // encoder position width, ticks
    localparam int POSITION_WIDTH = 18;
    localparam int GAIN_W         = 16;

    // pd arithmetic widths
    localparam int ERR_W    = POSITION_WIDTH + 1;
    localparam int DIFF_W   = POSITION_WIDTH + 2;
    localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
    localparam int PROD_D_W = GAIN_W + 1 + DIFF_W;
    localparam int SUM_W    = PROD_D_W + 1;

    // stream word widths
    localparam int IN_FIELDS_W = POSITION_WIDTH + 11;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 16;

    // configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_KP_GAIN    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KD_GAIN    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RAISED_TGT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PLACE_TGT  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SLOW_THR   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SLOWER_THR = 3'd5;

    // register reset values
    localparam logic [GAIN_W-1:0] KP_GAIN_RST = 16'd218;
    localparam logic [GAIN_W-1:0] KD_GAIN_RST = 16'd77;
    localparam logic signed [POSITION_WIDTH-1:0] RAISED_TGT_RST = POSITION_WIDTH'(-400);
    localparam logic signed [POSITION_WIDTH-1:0] PLACE_TGT_RST  = POSITION_WIDTH'(-4850);
    localparam logic signed [POSITION_WIDTH-1:0] SLOW_THR_RST   = POSITION_WIDTH'(-3000);
    localparam logic signed [POSITION_WIDTH-1:0] SLOWER_THR_RST = POSITION_WIDTH'(-4000);

    // speed caps and stick deadband
    localparam logic [6:0]        CAP_FULL   = 7'd127;
    localparam logic [6:0]        CAP_SLOW   = 7'd90;
    localparam logic [6:0]        CAP_SLOWER = 7'd50;
    localparam logic signed [7:0] DEADBAND   = 8'sd10;
    localparam logic signed [7:0] JOY_MIN    = -8'sd128;
    localparam logic signed [7:0] JOY_MAX    = 8'sd127;

    typedef enum logic [1:0] {
        MODE_HOME   = 2'd0,
        MODE_RAISED = 2'd1,
        MODE_HOLD   = 2'd2
    } t_mode;

    typedef struct packed {
        logic [GAIN_W-1:0]                kp_gain_q8;
        logic [GAIN_W-1:0]                kd_gain_q8;
        logic signed [POSITION_WIDTH-1:0] raised_target;
        logic signed [POSITION_WIDTH-1:0] place_target;
        logic signed [POSITION_WIDTH-1:0] slow_threshold;
        logic signed [POSITION_WIDTH-1:0] slower_threshold;
    } t_cfg;

    typedef struct packed {
        logic                             limit_pressed;
        logic                             toggle_press;
        logic                             place_button;
        logic signed [7:0]                joystick;
        logic signed [POSITION_WIDTH-1:0] position;
    } t_item;

    typedef struct packed {
        logic              placing;
        logic              zero_encoder;
        logic signed [7:0] motor_command;
    } t_result;

endpackage

`default_nettype wire

>>> hw/rtl/tapd_regs.sv
// tapd_regs: apb register file holding gains, targets and band thresholds
// depends on tapd_pkg
`timescale 1ns / 1ps
`default_nettype none

module tapd_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tapd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [tapd_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [tapd_pkg::APB_DATA_W-1:0] prdata,
    output tapd_pkg::t_cfg                       o_cfg
);
    import tapd_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] w_idx;
    logic                 w_wr;

    assign w_idx = paddr[APB_ADDR_W-1:2];
    assign w_wr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_gain_q8       <= KP_GAIN_RST;
            r_cfg.kd_gain_q8       <= KD_GAIN_RST;
            r_cfg.raised_target    <= RAISED_TGT_RST;
            r_cfg.place_target     <= PLACE_TGT_RST;
            r_cfg.slow_threshold   <= SLOW_THR_RST;
            r_cfg.slower_threshold <= SLOWER_THR_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_KP_GAIN:    r_cfg.kp_gain_q8       <= pwdata[GAIN_W-1:0];
                REG_KD_GAIN:    r_cfg.kd_gain_q8       <= pwdata[GAIN_W-1:0];
                REG_RAISED_TGT: r_cfg.raised_target    <= pwdata[POSITION_WIDTH-1:0];
                REG_PLACE_TGT:  r_cfg.place_target     <= pwdata[POSITION_WIDTH-1:0];
                REG_SLOW_THR:   r_cfg.slow_threshold   <= pwdata[POSITION_WIDTH-1:0];
                REG_SLOWER_THR: r_cfg.slower_threshold <= pwdata[POSITION_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // read mux, signed registers sign extended
    always_comb begin
        unique case (w_idx)
            REG_KP_GAIN:    prdata = APB_DATA_W'(r_cfg.kp_gain_q8);
            REG_KD_GAIN:    prdata = APB_DATA_W'(r_cfg.kd_gain_q8);
            REG_RAISED_TGT: prdata = APB_DATA_W'(r_cfg.raised_target);
            REG_PLACE_TGT:  prdata = APB_DATA_W'(r_cfg.place_target);
            REG_SLOW_THR:   prdata = APB_DATA_W'(r_cfg.slow_threshold);
            REG_SLOWER_THR: prdata = APB_DATA_W'(r_cfg.slower_threshold);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> hw/rtl/tapd_core.sv
// tapd_core: controller state (mode, place flag, previous error) and the
// one-pass pd step; depends on tapd_pkg
`timescale 1ns / 1ps
`default_nettype none

module tapd_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire tapd_pkg::t_item i_item,
    input  wire tapd_pkg::t_cfg  i_cfg,
    output tapd_pkg::t_result    o_res
);
    import tapd_pkg::*;

    t_mode                            r_mode, n_mode;
    logic                             r_place, n_place;
    logic signed [ERR_W-1:0]          r_prev_err, n_prev_err;

    t_mode                            w_mode_tog;
    logic signed [POSITION_WIDTH-1:0] w_pos, w_pos_eff, w_target;
    logic signed [7:0]                w_joy, w_joy_neg, w_power, w_motor;
    logic                             w_place1, w_stick_active;
    logic [6:0]                       w_cap, w_mag_clamped;
    logic signed [ERR_W-1:0]          w_err;
    logic signed [DIFF_W-1:0]         w_diff;
    logic signed [GAIN_W:0]           w_kp, w_kd;
    logic signed [PROD_P_W-1:0]       w_prod_p;
    logic signed [PROD_D_W-1:0]       w_prod_d;
    logic signed [SUM_W-1:0]          w_sum;
    logic [SUM_W-1:0]                 w_abs;
    logic [SUM_W-9:0]                 w_shr;

    assign w_pos = i_item.position;
    assign w_joy = i_item.joystick;

    // mode after the toggle press
    always_comb begin
        if (i_item.toggle_press) begin
            w_mode_tog = (r_mode == MODE_HOME) ? MODE_RAISED : MODE_HOME;
        end else begin
            w_mode_tog = r_mode;
        end
    end

    // target from the mode, place press overrides
    always_comb begin
        unique case (w_mode_tog)
            MODE_HOME:   w_target = '0;
            MODE_RAISED: w_target = i_cfg.raised_target;
            default:     w_target = w_pos;
        endcase
        if (i_item.place_button) begin
            w_target = i_cfg.place_target;
        end
    end

    // next mode
    always_comb begin
        n_mode = w_mode_tog;
        if (i_item.place_button) begin
            n_mode = MODE_HOLD;
        end
        if (i_item.limit_pressed && (w_joy > DEADBAND)) begin
            n_mode = MODE_HOLD;
        end
    end

    assign w_place1 = i_item.place_button | r_place;

    // speed cap by position band while placing
    always_comb begin
        w_cap = CAP_FULL;
        if (w_place1) begin
            if (w_pos >= i_cfg.slow_threshold) begin
                w_cap = CAP_FULL;
            end else if (w_pos > i_cfg.slower_threshold) begin
                w_cap = CAP_SLOW;
            end else if ((w_pos < i_cfg.slower_threshold) &&
                         (w_pos >= i_cfg.place_target)) begin
                w_cap = CAP_SLOWER;
            end
        end
    end

    // pd term
    assign w_err    = ERR_W'(w_target) - ERR_W'(w_pos);
    assign w_diff   = DIFF_W'(w_err) - DIFF_W'(r_prev_err);
    assign w_kp     = {1'b0, i_cfg.kp_gain_q8};
    assign w_kd     = {1'b0, i_cfg.kd_gain_q8};
    assign w_prod_p = w_kp * w_err;
    assign w_prod_d = w_kd * w_diff;
    assign w_sum    = SUM_W'(w_prod_p) + SUM_W'(w_prod_d);
    assign w_abs    = w_sum[SUM_W-1] ? unsigned'(-w_sum) : unsigned'(w_sum);
    assign w_shr    = w_abs[SUM_W-1:8];

    // truncate toward zero, then clamp magnitude to the cap
    always_comb begin
        if ((|w_shr[SUM_W-9:7]) || (w_shr[6:0] > w_cap)) begin
            w_mag_clamped = w_cap;
        end else begin
            w_mag_clamped = w_shr[6:0];
        end
    end

    assign w_power   = w_sum[SUM_W-1] ? -$signed({1'b0, w_mag_clamped})
                                      :  $signed({1'b0, w_mag_clamped});
    assign w_joy_neg = (w_joy == JOY_MIN) ? JOY_MAX : -w_joy;

    // stick override
    always_comb begin
        if (i_item.limit_pressed) begin
            w_stick_active = (w_joy > DEADBAND);
        end else begin
            w_stick_active = !((w_joy < DEADBAND) && (w_joy > -DEADBAND));
        end
    end

    assign w_motor   = w_stick_active ? w_joy_neg : w_power;
    assign w_pos_eff = i_item.limit_pressed ? '0 : w_pos;

    // place flag clears once past the place target
    assign n_place    = w_place1 & ~(w_pos_eff < i_cfg.place_target);
    assign n_prev_err = w_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_HOME;
            r_place    <= 1'b0;
            r_prev_err <= '0;
        end else if (i_step) begin
            r_mode     <= n_mode;
            r_place    <= n_place;
            r_prev_err <= n_prev_err;
        end
    end

    assign o_res.motor_command = w_motor;
    assign o_res.zero_encoder  = i_item.limit_pressed;
    assign o_res.placing       = n_place;

endmodule

`default_nettype wire

>>> hw/rtl/tray_angle_pd_controller.sv
// tray_angle_pd_controller: top level, stream handshake, input and result
// registers; instantiates tapd_regs and tapd_core, uses tapd_pkg
//
// channel   | direction | handshake                  | word contents
// s_axis    | in        | tvalid / tready            | one control tick sample
// m_axis    | out       | tvalid / tready            | drive value and flags
// apb       | in        | psel / penable, pready = 1 | gains, targets, thresholds
//
// one word per cycle sustained while m_axis takes words; a word passes through the input
// register, and the pd step runs in one pass from there into the result register
// i_rst_n is synchronous; it empties both stages and puts the controller in home
// mode with the place flag and previous error cleared
// a stalled m_axis holds the result; the input register keeps taking words
// until both stages are full, then s_axis_tready drops
`timescale 1ns / 1ps
`default_nettype none

module tray_angle_pd_controller (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // slave stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [POSITION_WIDTH-1:0] position, then joystick (8), place_button,
    // toggle_press, limit_pressed, zero fill
    input  wire logic [tapd_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // master stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [7:0] motor_command, [8] zero_encoder, [9] placing, zero fill
    output logic [tapd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tapd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [tapd_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [tapd_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import tapd_pkg::*;

    t_cfg    w_cfg;
    t_item   r_in;
    t_result r_out, w_res;
    logic    r_in_valid, r_out_valid;
    logic    w_out_free;   // result register can take a word this cycle
    logic    w_adv;        // input stage moves into the result stage

    assign pready = 1'b1;

    tapd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    // handshake: a stage is free when empty or when its word leaves this cycle
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_adv         = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    // input register, payload unreset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.position      <= s_axis_tdata[POSITION_WIDTH-1:0];
            r_in.joystick      <= s_axis_tdata[POSITION_WIDTH+7:POSITION_WIDTH];
            r_in.place_button  <= s_axis_tdata[POSITION_WIDTH+8];
            r_in.toggle_press  <= s_axis_tdata[POSITION_WIDTH+9];
            r_in.limit_pressed <= s_axis_tdata[POSITION_WIDTH+10];
        end
    end

    // pd step and controller state, state advances with the word
    tapd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_item  (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out.placing, r_out.zero_encoder,
                                         r_out.motor_command});

    // back-pressure only when both stages hold a word
    a_ready_low_only_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid))
        else $error("s_axis_tready low with a free stage");

    // an accepted word sits in the input register next cycle
    a_accept_loads : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_in_valid)
        else $error("accepted word lost");

    // encoder zero request follows the limit switch of the same word
    a_zero_follows_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (r_out.zero_encoder == $past(r_in.limit_pressed)))
        else $error("zero_encoder does not match limit switch");

    // stick push at the limit always drives the tray up (negative command)
    a_limit_stick_drive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in.limit_pressed && (r_in.joystick > DEADBAND))
            |=> (r_out.motor_command < 0))
        else $error("stick override at limit gave wrong sign");

    // both stages empty after reset
    a_reset_empty : assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!r_in_valid && !r_out_valid))
        else $error("stages not empty after reset");

endmodule

`default_nettype wire
